>>> hdl/bmp_header_checker_defines.svh
// Assertion macros shared by the verification code of the bitmap header checker.
// Included by the checker module; depends on nothing else.
`ifndef BMP_HEADER_CHECKER_DEFINES_SVH
`define BMP_HEADER_CHECKER_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define BHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BHC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hdl/bhc_pkg.sv
// Package of the bitmap header checker: result codes, header byte positions
// and stream widths. Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package bhc_pkg;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC_B = 3'd1,
        ST_BAD_MAGIC_M = 3'd2,
        ST_BAD_OFFSET  = 3'd3,
        ST_BAD_DEPTH   = 3'd4,
        ST_COMPRESSED  = 3'd5,
        ST_BAD_DIM     = 3'd6
    } status_t;

    localparam logic [7:0] MAGIC_FIRST  = 8'h42;  // 'B'
    localparam logic [7:0] MAGIC_SECOND = 8'h4D;  // 'M'

    localparam int FILE_HDR_BYTES   = 14;
    localparam int INFO_HDR_BYTES   = 40;
    localparam int HEADER_BYTES     = FILE_HDR_BYTES + INFO_HDR_BYTES;
    localparam int TRUE_COLOR_DEPTH = 24;
    localparam int BYTES_PER_PIXEL  = 3;

    // First byte position of each little-endian header field.
    localparam int POS_OFFSET = 10;
    localparam int POS_WIDTH  = 18;
    localparam int POS_HEIGHT = 22;
    localparam int POS_DEPTH  = 28;
    localparam int POS_COMPR  = 30;
    localparam int POS_LAST   = 33;

    localparam int POS_W = 6;

    localparam int STATUS_W = 3;
    localparam int PIXW_W   = 16;
    localparam int ROW_W    = 18;
    localparam int IMG_W    = 34;

    localparam int OUT_FIELDS_W = STATUS_W + 2 * PIXW_W + ROW_W + IMG_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

>>> hdl/bmp_header_checker.sv
// Top level of the bitmap header checker: byte stream in, one header verdict out.
// Depends on bhc_pkg.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                  Handshake
// s_        in   tdata[7:0] file byte, tuser start flag    s_tvalid / s_tready
// m_        out  tdata status,width,height,row,image      m_tvalid / m_tready
//
// One byte is taken per clock cycle while s_tready is high. The input register
// holds the transferred byte; the parser state and the pending verdict register
// take the parser's result for it; the output register, with the row/image
// multiplier in front of it, takes the verdict from the pending register.
// Reset (aresetn low, synchronous) empties all three registers and leaves the
// parser waiting for a byte with the start flag set.
// Each stage holds its item only while the stage after it is full and stalled,
// so bytes keep flowing while one result waits and the pending stage is empty.
module bmp_header_checker #(
    parameter int DIM_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] start_of_file

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status, [18:3] pixel_width, [34:19] pixel_height,
    // [52:35] row_bytes, [86:53] image_bytes, upper bits zero
    output logic [bhc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // Row length needs two bits above the width; the product covers both.
    localparam int ROW_FULL_W = DIM_BITS + 2;
    localparam int PROD_W     = DIM_BITS + ROW_FULL_W;
    localparam int EXT_W      = PROD_W + bhc_pkg::IMG_W;

    // Input register stage.
    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_sof_reg;

    // Parser state, updated when the input register hands its byte on.
    logic [bhc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      done_reg, done_next;
    logic [31:0]               offset_reg, offset_next;
    logic [31:0]               width_reg, width_next;
    logic [31:0]               height_reg, height_next;
    logic [15:0]               depth_reg, depth_next;
    logic [31:0]               compr_reg, compr_next;

    // Position of the byte in the input register, zero when it starts a file.
    logic [bhc_pkg::POS_W-1:0] pos_cur;

    // Pending verdict stage between the parser and the output register.
    logic                  p_valid_reg;
    bhc_pkg::status_t      p_status_reg;
    logic [DIM_BITS-1:0]   p_width_reg;
    logic [DIM_BITS-1:0]   p_height_reg;

    // Parser verdict for the byte currently in the input register.
    logic                  res_valid;
    bhc_pkg::status_t      res_status;
    logic [DIM_BITS-1:0]   res_width;
    logic [DIM_BITS-1:0]   res_height;

    // Output register stage.
    logic                      m_valid_reg;
    bhc_pkg::status_t          m_status_reg;
    logic [bhc_pkg::PIXW_W-1:0] m_width_reg;
    logic [bhc_pkg::PIXW_W-1:0] m_height_reg;
    logic [bhc_pkg::ROW_W-1:0]  m_row_reg;
    logic [bhc_pkg::IMG_W-1:0]  m_img_reg;

    logic out_ready;
    logic p_ready;
    logic a_fire;

    // Geometry arithmetic in front of the output register.
    logic [ROW_FULL_W-1:0] row_full;
    logic [PROD_W-1:0]     img_full;
    logic [EXT_W-1:0]      width_ext;
    logic [EXT_W-1:0]      height_ext;
    logic [EXT_W-1:0]      row_ext;
    logic [EXT_W-1:0]      img_ext;

    // Byte lane selects inside each captured field.
    logic [1:0] lane_offset;
    logic [1:0] lane_width;
    logic [1:0] lane_height;
    logic       lane_depth;
    logic [1:0] lane_compr;

    // Each stage can load when it is empty or when its content moves on.
    assign out_ready = !m_valid_reg || m_tready;
    assign p_ready   = !p_valid_reg || out_ready;
    assign s_tready  = !a_valid_reg || p_ready;
    assign a_fire    = a_valid_reg && p_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            a_byte_reg <= s_tdata;
            a_sof_reg  <= s_tuser;
        end
    end

    assign pos_cur = a_sof_reg ? '0 : pos_reg;

    assign lane_offset = 2'(pos_cur - bhc_pkg::POS_W'(bhc_pkg::POS_OFFSET));
    assign lane_width  = 2'(pos_cur - bhc_pkg::POS_W'(bhc_pkg::POS_WIDTH));
    assign lane_height = 2'(pos_cur - bhc_pkg::POS_W'(bhc_pkg::POS_HEIGHT));
    assign lane_depth  = 1'(pos_cur - bhc_pkg::POS_W'(bhc_pkg::POS_DEPTH));
    assign lane_compr  = 2'(pos_cur - bhc_pkg::POS_W'(bhc_pkg::POS_COMPR));

    // Parser. The *_next signals first take the state as seen by this byte
    // (cleared when the start flag is set), then the captured byte, then the
    // advanced position. The lane selects read the position before it moves.
    always_comb begin
        done_next   = a_sof_reg ? 1'b0 : done_reg;
        offset_next = a_sof_reg ? '0 : offset_reg;
        width_next  = a_sof_reg ? '0 : width_reg;
        height_next = a_sof_reg ? '0 : height_reg;
        depth_next  = a_sof_reg ? '0 : depth_reg;
        compr_next  = a_sof_reg ? '0 : compr_reg;
        pos_next    = pos_cur;

        res_valid  = 1'b0;
        res_status = bhc_pkg::ST_OK;
        res_width  = '0;
        res_height = '0;

        if (!done_next) begin
            if (pos_cur == '0 && a_byte_reg != bhc_pkg::MAGIC_FIRST) begin
                done_next  = 1'b1;
                res_valid  = 1'b1;
                res_status = bhc_pkg::ST_BAD_MAGIC_B;
            end else if (pos_cur == bhc_pkg::POS_W'(1)
                         && a_byte_reg != bhc_pkg::MAGIC_SECOND) begin
                done_next  = 1'b1;
                res_valid  = 1'b1;
                res_status = bhc_pkg::ST_BAD_MAGIC_M;
            end else begin
                priority if (pos_cur >= bhc_pkg::POS_W'(bhc_pkg::POS_OFFSET)
                             && pos_cur < bhc_pkg::POS_W'(bhc_pkg::POS_OFFSET + 4)) begin
                    offset_next[{lane_offset, 3'b000} +: 8] = a_byte_reg;
                end else if (pos_cur >= bhc_pkg::POS_W'(bhc_pkg::POS_WIDTH)
                             && pos_cur < bhc_pkg::POS_W'(bhc_pkg::POS_WIDTH + 4)) begin
                    width_next[{lane_width, 3'b000} +: 8] = a_byte_reg;
                end else if (pos_cur >= bhc_pkg::POS_W'(bhc_pkg::POS_HEIGHT)
                             && pos_cur < bhc_pkg::POS_W'(bhc_pkg::POS_HEIGHT + 4)) begin
                    height_next[{lane_height, 3'b000} +: 8] = a_byte_reg;
                end else if (pos_cur >= bhc_pkg::POS_W'(bhc_pkg::POS_DEPTH)
                             && pos_cur < bhc_pkg::POS_W'(bhc_pkg::POS_DEPTH + 2)) begin
                    depth_next[{lane_depth, 3'b000} +: 8] = a_byte_reg;
                end else if (pos_cur >= bhc_pkg::POS_W'(bhc_pkg::POS_COMPR)
                             && pos_cur < bhc_pkg::POS_W'(bhc_pkg::POS_COMPR + 4)) begin
                    compr_next[{lane_compr, 3'b000} +: 8] = a_byte_reg;
                end else begin
                    offset_next = offset_next;
                end

                if (pos_cur < bhc_pkg::POS_W'(bhc_pkg::POS_LAST)) begin
                    pos_next = pos_cur + bhc_pkg::POS_W'(1);
                end else begin
                    // Last header byte: the checks run in priority order.
                    done_next = 1'b1;
                    res_valid = 1'b1;
                    priority if (offset_next != 32'(bhc_pkg::HEADER_BYTES)) begin
                        res_status = bhc_pkg::ST_BAD_OFFSET;
                    end else if (depth_next != 16'(bhc_pkg::TRUE_COLOR_DEPTH)) begin
                        res_status = bhc_pkg::ST_BAD_DEPTH;
                    end else if (compr_next != '0) begin
                        res_status = bhc_pkg::ST_COMPRESSED;
                    end else if (width_next[31:DIM_BITS] != '0
                                 || height_next[31:DIM_BITS] != '0) begin
                        res_status = bhc_pkg::ST_BAD_DIM;
                    end else begin
                        res_status = bhc_pkg::ST_OK;
                        res_width  = width_next[DIM_BITS-1:0];
                        res_height = height_next[DIM_BITS-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            done_reg <= 1'b1;
        end else if (a_fire) begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
        if (a_fire) begin
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            compr_reg  <= compr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_ready) begin
            p_valid_reg <= a_fire && res_valid;
        end
        if (p_ready) begin
            p_status_reg <= res_status;
            p_width_reg  <= res_width;
            p_height_reg <= res_height;
        end
    end

    // Row length: width * 3 rounded up to a multiple of four. An error
    // verdict carries zero geometry, which gives zero row and image sizes.
    assign row_full = (ROW_FULL_W'(p_width_reg) + {1'b0, p_width_reg, 1'b0}
                       + ROW_FULL_W'(bhc_pkg::BYTES_PER_PIXEL))
                      & ~ROW_FULL_W'(3);
    assign img_full = PROD_W'(p_height_reg) * PROD_W'(row_full);

    assign width_ext  = EXT_W'(p_width_reg);
    assign height_ext = EXT_W'(p_height_reg);
    assign row_ext    = EXT_W'(row_full);
    assign img_ext    = EXT_W'(img_full);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= p_valid_reg;
        end
        if (out_ready) begin
            m_status_reg <= p_status_reg;
            m_width_reg  <= width_ext[bhc_pkg::PIXW_W-1:0];
            m_height_reg <= height_ext[bhc_pkg::PIXW_W-1:0];
            m_row_reg    <= row_ext[bhc_pkg::ROW_W-1:0];
            m_img_reg    <= img_ext[bhc_pkg::IMG_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = bhc_pkg::OUT_TDATA_W'({m_img_reg, m_row_reg, m_height_reg,
                                             m_width_reg, m_status_reg});

endmodule

>>> hdl/bhc_checker.sv
// Port-level checker for the bitmap header checker, bound to its top level.
// Depends on bhc_pkg and bmp_header_checker_defines.svh.
`timescale 1ns / 1ps
`include "bmp_header_checker_defines.svh"

module bhc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bhc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic ok_result;
    logic geometry_zero;

    assign ok_result     = m_tdata[2:0] == bhc_pkg::ST_OK;
    assign geometry_zero = m_tdata[bhc_pkg::OUT_FIELDS_W-1:bhc_pkg::STATUS_W] == '0;

    // No result may be pending right after a reset cycle.
    `BHC_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_tvalid, "result valid after reset")

    // A result needs a byte to pass three register stages after reset.
    `BHC_ASSERT(a_no_early_result, $rose(m_tvalid) |-> $past(aresetn) && $past(aresetn, 2),
        "result appeared too soon after reset")

    // Error verdicts carry no geometry.
    `BHC_ASSERT(a_error_zero_geometry, m_tvalid && !ok_result |-> geometry_zero,
        "error result with nonzero geometry")

    // A stalled result holds its value.
    `BHC_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "stalled result changed")

endmodule

bind bmp_header_checker bhc_checker u_bhc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/testbench.sv
// Self-checking testbench for bmp_header_checker: drives bitmap headers, broken
// headers and stray bytes, predicts each verdict and checks it. Depends on bhc_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int DIM_BITS       = 16;
    localparam int CLK_HALF_NS    = 4;
    localparam int RANDOM_BYTES   = 1050;   // header bytes in the random part
    localparam int WATCHDOG_LIMIT = 2000;   // cycles without any transfer
    localparam int DRAIN_CYCLES   = 16;     // wait after the last verdict
    localparam int MAX_REPORTS    = 10;

    // Number of bytes in a complete header, up to and including the verdict byte.
    localparam int FULL_HEADER = bhc_pkg::POS_LAST + 1;

    // Field values of a well-formed header.
    localparam logic [7:0]  MAGIC_B     = bhc_pkg::MAGIC_FIRST;
    localparam logic [7:0]  MAGIC_M     = bhc_pkg::MAGIC_SECOND;
    localparam logic [31:0] GOOD_OFFSET = 32'(bhc_pkg::HEADER_BYTES);
    localparam logic [15:0] GOOD_DEPTH  = 16'(bhc_pkg::TRUE_COLOR_DEPTH);

    // Bit offsets of the result fields inside m_tdata, lowest field first.
    localparam int OFS_WIDTH  = bhc_pkg::STATUS_W;
    localparam int OFS_HEIGHT = OFS_WIDTH + bhc_pkg::PIXW_W;
    localparam int OFS_ROW    = OFS_HEIGHT + bhc_pkg::PIXW_W;
    localparam int OFS_IMG    = OFS_ROW + bhc_pkg::ROW_W;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } file_byte_t;

    typedef struct packed {
        bhc_pkg::status_t             status;
        logic [bhc_pkg::PIXW_W-1:0]   pixel_width;
        logic [bhc_pkg::PIXW_W-1:0]   pixel_height;
        logic [bhc_pkg::ROW_W-1:0]    row_bytes;
        logic [bhc_pkg::IMG_W-1:0]    image_bytes;
    } header_verdict_t;

    // Receiver behavior, chosen anew for each run of cycles.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKED
    } rx_mode_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata  = 8'd0;   // [7:0] data_byte
    logic                            s_tuser  = 1'b0;   // [0] start_of_file

    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [2:0] status, [18:3] pixel_width, [34:19] pixel_height,
    // [52:35] row_bytes, [86:53] image_bytes, upper bits zero
    logic [bhc_pkg::OUT_TDATA_W-1:0] m_tdata;

    bmp_header_checker #(
        .DIM_BITS (DIM_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Bytes still to be sent, and verdicts that the checker still owes us.
    file_byte_t      byte_q[$];
    header_verdict_t verdict_q[$];

    // Shadow copy of the parser state, kept in step with accepted bytes.
    logic [bhc_pkg::POS_W-1:0] hdr_pos    = '0;
    logic                      hdr_done   = 1'b1;   // waits for a start flag after reset
    logic [31:0]               hdr_offset = '0;
    logic [31:0]               hdr_width  = '0;
    logic [31:0]               hdr_height = '0;
    logic [15:0]               hdr_depth  = '0;
    logic [31:0]               hdr_compr  = '0;

    int fail_count  = 0;
    int idle_cycles = 0;

    // Sender state: holding is set while a byte sits on the bus unaccepted.
    logic holding    = 1'b0;
    int   burst_left = 0;
    int   gap_left   = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    initial begin
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    // Advances the shadow parser by one accepted byte. A verdict is queued when
    // a magic byte is wrong or when the last header byte arrives.
    task automatic parse_file_byte(input logic [7:0] b, input logic start);
        header_verdict_t v;
        int              idx;
        logic [63:0]     row64;
        logic [63:0]     img64;
        v = '0;
        if (start) begin
            hdr_pos    = '0;
            hdr_offset = '0;
            hdr_width  = '0;
            hdr_height = '0;
            hdr_depth  = '0;
            hdr_compr  = '0;
            hdr_done   = 1'b0;
        end
        if (hdr_done) return;

        idx = int'(hdr_pos);
        if (idx == 0 && b != MAGIC_B) begin
            hdr_done = 1'b1;
            v.status = bhc_pkg::ST_BAD_MAGIC_B;
            verdict_q.push_back(v);
            return;
        end
        if (idx == 1 && b != MAGIC_M) begin
            hdr_done = 1'b1;
            v.status = bhc_pkg::ST_BAD_MAGIC_M;
            verdict_q.push_back(v);
            return;
        end

        // All header fields are little endian.
        if (idx >= bhc_pkg::POS_OFFSET && idx < bhc_pkg::POS_OFFSET + 4)
            hdr_offset[(idx - bhc_pkg::POS_OFFSET) * 8 +: 8] = b;
        else if (idx >= bhc_pkg::POS_WIDTH && idx < bhc_pkg::POS_WIDTH + 4)
            hdr_width[(idx - bhc_pkg::POS_WIDTH) * 8 +: 8] = b;
        else if (idx >= bhc_pkg::POS_HEIGHT && idx < bhc_pkg::POS_HEIGHT + 4)
            hdr_height[(idx - bhc_pkg::POS_HEIGHT) * 8 +: 8] = b;
        else if (idx >= bhc_pkg::POS_DEPTH && idx < bhc_pkg::POS_DEPTH + 2)
            hdr_depth[(idx - bhc_pkg::POS_DEPTH) * 8 +: 8] = b;
        else if (idx >= bhc_pkg::POS_COMPR && idx < bhc_pkg::POS_COMPR + 4)
            hdr_compr[(idx - bhc_pkg::POS_COMPR) * 8 +: 8] = b;

        if (idx < bhc_pkg::POS_LAST) begin
            hdr_pos = hdr_pos + bhc_pkg::POS_W'(1);
            return;
        end

        // Last header byte: report only the first check that fails.
        hdr_done = 1'b1;
        if (hdr_offset != GOOD_OFFSET) begin
            v.status = bhc_pkg::ST_BAD_OFFSET;
        end else if (hdr_depth != GOOD_DEPTH) begin
            v.status = bhc_pkg::ST_BAD_DEPTH;
        end else if (hdr_compr != 32'd0) begin
            v.status = bhc_pkg::ST_COMPRESSED;
        end else if (({32'd0, hdr_width} >> DIM_BITS) != 64'd0 ||
                     ({32'd0, hdr_height} >> DIM_BITS) != 64'd0) begin
            // Dimensions are unsigned, so a negative height lands here too.
            v.status = bhc_pkg::ST_BAD_DIM;
        end else begin
            // Rows are padded to whole 32-bit words.
            row64 = ({32'd0, hdr_width} * 64'(bhc_pkg::BYTES_PER_PIXEL) + 64'd3) & ~64'd3;
            img64 = {32'd0, hdr_height} * row64;
            v.status       = bhc_pkg::ST_OK;
            v.pixel_width  = hdr_width[bhc_pkg::PIXW_W-1:0];
            v.pixel_height = hdr_height[bhc_pkg::PIXW_W-1:0];
            v.row_bytes    = row64[bhc_pkg::ROW_W-1:0];
            v.image_bytes  = img64[bhc_pkg::IMG_W-1:0];
        end
        verdict_q.push_back(v);
    endtask

    // Queues one file: the first len header bytes, then tail bytes that the
    // checker should ignore. Bytes outside the checked fields are random.
    task automatic queue_header(input logic [7:0] m0, input logic [7:0] m1,
                                input logic [31:0] ofs, input logic [31:0] wid,
                                input logic [31:0] hgt, input logic [15:0] dep,
                                input logic [31:0] cmp, input int len, input int tail);
        file_byte_t fb;
        logic [7:0] b;
        for (int p = 0; p < len + tail; p++) begin
            b = 8'($urandom);
            if (p == 0)
                b = m0;
            else if (p == 1)
                b = m1;
            else if (p >= bhc_pkg::POS_OFFSET && p < bhc_pkg::POS_OFFSET + 4)
                b = ofs[(p - bhc_pkg::POS_OFFSET) * 8 +: 8];
            else if (p >= bhc_pkg::POS_WIDTH && p < bhc_pkg::POS_WIDTH + 4)
                b = wid[(p - bhc_pkg::POS_WIDTH) * 8 +: 8];
            else if (p >= bhc_pkg::POS_HEIGHT && p < bhc_pkg::POS_HEIGHT + 4)
                b = hgt[(p - bhc_pkg::POS_HEIGHT) * 8 +: 8];
            else if (p >= bhc_pkg::POS_DEPTH && p < bhc_pkg::POS_DEPTH + 2)
                b = dep[(p - bhc_pkg::POS_DEPTH) * 8 +: 8];
            else if (p >= bhc_pkg::POS_COMPR && p < bhc_pkg::POS_COMPR + 4)
                b = cmp[(p - bhc_pkg::POS_COMPR) * 8 +: 8];
            fb.data  = b;
            fb.start = (p == 0);
            byte_q.push_back(fb);
        end
    endtask

    // Queues stray bytes; with allow_start set, about one in eight restarts a parse.
    task automatic queue_noise(input int n, input bit allow_start);
        file_byte_t fb;
        for (int i = 0; i < n; i++) begin
            fb.data  = 8'($urandom);
            fb.start = allow_start && ($urandom_range(0, 7) == 0);
            byte_q.push_back(fb);
        end
    endtask

    // Sender: presents queued bytes in bursts with random gaps in between. A byte
    // stays on the bus until it is taken, so gaps only open between transfers.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!holding) begin
            if (gap_left == 0 && byte_q.size() != 0) begin
                s_tdata  <= byte_q[0].data;
                s_tuser  <= byte_q[0].start;
                s_tvalid <= 1'b1;
                void'(byte_q.pop_front());
                holding = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    // Mostly short bursts, now and then a long unbroken stretch.
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 48);
                    case ($urandom_range(0, 3))
                        0, 1:    gap_left = 0;
                        2:       gap_left = $urandom_range(1, 4);
                        default: gap_left = $urandom_range(5, 30);
                    endcase
                end
            end else begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // Receiver: runs of open, coin-flip, sparse or fully blocked cycles.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    // Monitor: checks each result transfer against the oldest verdict, then
    // feeds each input transfer to the shadow parser.
    always @(posedge aclk) begin
        header_verdict_t want;
        header_verdict_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status       = bhc_pkg::status_t'(m_tdata[bhc_pkg::STATUS_W-1:0]);
                got.pixel_width  = m_tdata[OFS_WIDTH +: bhc_pkg::PIXW_W];
                got.pixel_height = m_tdata[OFS_HEIGHT +: bhc_pkg::PIXW_W];
                got.row_bytes    = m_tdata[OFS_ROW +: bhc_pkg::ROW_W];
                got.image_bytes  = m_tdata[OFS_IMG +: bhc_pkg::IMG_W];
                if (verdict_q.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected result: status %0d width %0d height %0d",
                                 got.status, got.pixel_width, got.pixel_height);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.status !== want.status ||
                        got.pixel_width !== want.pixel_width ||
                        got.pixel_height !== want.pixel_height ||
                        got.row_bytes !== want.row_bytes ||
                        got.image_bytes !== want.image_bytes) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display({"result mismatch: expected status %0d width %0d",
                                      " height %0d row %0d image %0d"},
                                     want.status, want.pixel_width, want.pixel_height,
                                     want.row_bytes, want.image_bytes);
                            $display({"                 actual   status %0d width %0d",
                                      " height %0d row %0d image %0d"},
                                     got.status, got.pixel_width, got.pixel_height,
                                     got.row_bytes, got.image_bytes);
                        end
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                parse_file_byte(s_tdata, s_tuser);
                holding = 1'b0;
            end

            // Watchdog: any transfer on either side counts as progress.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int          r;
        int          len;
        int          tail;
        int          header_bytes;
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [31:0] ofs;
        logic [31:0] wid;
        logic [31:0] hgt;
        logic [15:0] dep;
        logic [31:0] cmp;

        // Directed part. Stray bytes right after reset must be ignored.
        queue_noise(3, 1'b0);
        // Good headers; widths 1, 2 and 3 exercise the row padding, and the
        // tail after the first one must be ignored.
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'd1, 32'd1,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 3);
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'd2, 32'd7,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 0);
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'd3, 32'd5,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 0);
        // Zero dimensions are legal, and so is the largest image.
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'd0, 32'd0,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 0);
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'h0000_FFFF, 32'h0000_FFFF,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 0);
        // Wrong magic bytes answer early; the rest of the file is ignored.
        queue_header(8'h00, MAGIC_M, GOOD_OFFSET, 32'd4, 32'd4,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 2);
        queue_header(MAGIC_B, MAGIC_B, GOOD_OFFSET, 32'd4, 32'd4,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 0);
        // Priority: every check fails, so the offset is reported; then depth
        // over compression, then compression over a bad dimension.
        queue_header(MAGIC_B, MAGIC_M, 32'hFFFF_FFFF, 32'h0001_0000, 32'd5,
                     16'd8, 32'd1, FULL_HEADER, 0);
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'd5, 32'd5,
                     16'hFFFF, 32'd1, FULL_HEADER, 0);
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'h0001_0000, 32'd4,
                     GOOD_DEPTH, 32'hFFFF_FFFF, FULL_HEADER, 0);
        // Dimension range: one too wide, and a negative height.
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'h0001_0000, 32'd1,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 0);
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'd1, 32'hFFFF_FFFF,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 0);
        // A start flag in mid-header drops that parse without a result.
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'd10, 32'd10,
                     GOOD_DEPTH, 32'd0, 20, 0);
        queue_header(MAGIC_B, MAGIC_M, GOOD_OFFSET, 32'd640, 32'd480,
                     GOOD_DEPTH, 32'd0, FULL_HEADER, 0);

        // Random part: about half well-formed headers with random geometry, the
        // rest broken in one way or another.
        header_bytes = 0;
        while (header_bytes < RANDOM_BYTES) begin
            m0   = MAGIC_B;
            m1   = MAGIC_M;
            ofs  = GOOD_OFFSET;
            dep  = GOOD_DEPTH;
            cmp  = 32'd0;
            len  = FULL_HEADER;
            tail = $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    wid = $urandom_range(0, 2000);
                    hgt = $urandom_range(0, 2000);
                end
                7, 8: begin
                    wid = $urandom_range(0, 65535);
                    hgt = $urandom_range(0, 65535);
                end
                default: begin
                    wid = $urandom_range(0, 1) ? 32'h0000_FFFF : 32'd0;
                    hgt = $urandom_range(0, 1) ? 32'h0000_FFFF : 32'd0;
                end
            endcase
            r = $urandom_range(0, 99);
            if (r < 50) begin
                // Well-formed header.
            end else if (r < 58) begin
                ofs = $urandom_range(0, 1) ? $urandom
                                           : GOOD_OFFSET ^ (32'd1 << $urandom_range(0, 31));
                if (ofs == GOOD_OFFSET) ofs = ~ofs;
                if ($urandom_range(0, 1)) begin
                    dep = 16'($urandom);
                    cmp = $urandom;
                end
            end else if (r < 64) begin
                dep = 16'($urandom);
                if (dep == GOOD_DEPTH) dep = ~dep;
                if ($urandom_range(0, 1)) cmp = $urandom;
            end else if (r < 70) begin
                cmp = $urandom_range(0, 1) ? $urandom : (32'd1 << $urandom_range(0, 31));
                if (cmp == 32'd0) cmp = 32'd1;
                if ($urandom_range(0, 1)) wid = $urandom;
            end else if (r < 78) begin
                // Push width, height or both past the dimension range.
                case ($urandom_range(0, 2))
                    0:       wid[16 + $urandom_range(0, 15)] = 1'b1;
                    1:       hgt[16 + $urandom_range(0, 15)] = 1'b1;
                    default: begin
                        wid = $urandom | 32'h8000_0000;
                        hgt = $urandom | 32'h0001_0000;
                    end
                endcase
            end else if (r < 84) begin
                m0 = 8'($urandom);
                if (m0 == MAGIC_B) m0 = ~m0;
            end else if (r < 88) begin
                m1 = 8'($urandom);
                if (m1 == MAGIC_M) m1 = ~m1;
            end else if (r < 95) begin
                // Cut short; the next start flag abandons it.
                len  = $urandom_range(1, bhc_pkg::POS_LAST);
                tail = 0;
            end else begin
                queue_noise($urandom_range(1, 10), 1'b1);
                len  = 0;
                tail = 0;
            end
            if (len > 0)
                queue_header(m0, m1, ofs, wid, hgt, dep, cmp, len, tail);
            header_bytes += len;
        end

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every byte to be taken and every verdict to arrive, then
        // give the pipeline time to show any result it should not produce.
        while (byte_q.size() != 0 || holding) @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
